FILE: design/hcm_pkg.sv
// ----------------------------------------------------------------------------
// hcm_pkg
// Types and constants shared by the host command mailbox modules.
// ----------------------------------------------------------------------------
package hcm_pkg;

  // bus access kinds
  localparam logic [1:0] OP_HOST_WRITE = 2'd0;
  localparam logic [1:0] OP_HOST_READ  = 2'd1;
  localparam logic [1:0] OP_DSP_READ   = 2'd2;
  localparam logic [1:0] OP_DSP_WRITE  = 2'd3;

  // DSP io ports
  localparam logic [1:0] PORT_RAM_BANK = 2'd0;
  localparam logic [1:0] PORT_EXT_BANK = 2'd1;
  localparam logic [1:0] PORT_MAILBOX  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  port;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_request;
    logic [1:0]  ram_bank;
    logic [15:0] ext_bank;
    logic        dropped;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // execute the accepted transaction
    logic pop_commit;  // head word is in the read register: finish the pop
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fetch_needed;  // incoming transaction pops a waiting command
  } dp_status_t;

endpackage

FILE: design/host_command_mailbox.sv
// ----------------------------------------------------------------------------
// host_command_mailbox
// Host-to-DSP command mailbox with command FIFO, output latch and bank selects.
// ----------------------------------------------------------------------------
// Each bus access yields one result through an output register. Most
// transactions go straight to the result, and a new one is accepted in the
// same cycle the previous result is taken. A DSP read of port 3 that finds
// commands waiting adds a head-fetch state for the registered memory read.
// The FIFO holds FIFO_DEPTH slots with one always kept free.
module host_command_mailbox #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hcm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hcm_pkg::out_item_t out_item_o
);
  import hcm_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  hcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  hcm_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

`ifndef ASSERT_OFF
  // a dropped command still raises the interrupt
  a_drop_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.dropped || out_item_o.irq_request))
    else $error("dropped command without interrupt");

  // no transaction enters while a pop is completing
  a_fetch_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop_commit |-> !in_ready_o)
    else $error("transaction accepted during head fetch");

  // a simple transaction has its result in the following cycle
  a_simple_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !status.fetch_needed) |=> out_valid_o)
    else $error("result missing after transaction");

  // a pop transaction finishes in the next cycle and then shows its result
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status.fetch_needed) |=> ctrl.pop_commit ##1 out_valid_o)
    else $error("pop sequence broken");
`endif

endmodule

FILE: design/hcm_datapath.sv
// ----------------------------------------------------------------------------
// hcm_datapath
// Command FIFO memory, pointers, latch, bank registers and result register.
// ----------------------------------------------------------------------------
module hcm_datapath #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcm_pkg::in_item_t  in_item_i,
  input  hcm_pkg::ctrl_cmd_t ctrl_i,
  output hcm_pkg::dp_status_t status_o,
  output hcm_pkg::out_item_t  out_item_o
);
  import hcm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(FIFO_DEPTH - 1);

  logic [15:0]   mem_q [FIFO_DEPTH];
  logic [15:0]   head_q;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_next, wr_next;
  logic [15:0]   latch_q, latch_d;
  logic          ready_flag_q, ready_flag_d;
  logic [1:0]    ram_bank_q, ram_bank_d;
  logic [15:0]   ext_bank_q, ext_bank_d;
  logic          irq_q, irq_d;
  logic [15:0]   read_data_q, read_data_d;
  logic          dropped_q, dropped_d;
  logic          fifo_full, fifo_empty, mem_we;

  assign rd_next    = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PW'(1);
  assign wr_next    = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PW'(1);
  assign fifo_full  = (wr_next == rd_ptr_q);
  assign fifo_empty = (rd_ptr_q == wr_ptr_q);

  assign status_o.fetch_needed = (in_item_i.cmd == OP_DSP_READ) &&
                                 (in_item_i.port == PORT_MAILBOX) && !fifo_empty;

  assign mem_we = ctrl_i.load_item && (in_item_i.cmd == OP_HOST_WRITE) && !fifo_full;

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    latch_d      = latch_q;
    ready_flag_d = ready_flag_q;
    ram_bank_d   = ram_bank_q;
    ext_bank_d   = ext_bank_q;
    irq_d        = irq_q;
    read_data_d  = read_data_q;
    dropped_d    = dropped_q;
    if (ctrl_i.pop_commit) begin
      read_data_d = head_q;
      rd_ptr_d    = rd_next;
      irq_d       = (rd_next != wr_ptr_q);
    end else if (ctrl_i.load_item) begin
      read_data_d = '0;
      dropped_d   = 1'b0;
      unique case (in_item_i.cmd)
        OP_HOST_WRITE: begin
          if (fifo_full) begin
            dropped_d = 1'b1;
          end else begin
            wr_ptr_d = wr_next;
          end
          irq_d = 1'b1;
        end
        OP_HOST_READ: begin
          if (in_item_i.port[1]) begin
            read_data_d  = latch_q;
            ready_flag_d = 1'b1;
          end else begin
            read_data_d = {15'd0, ready_flag_q};
          end
        end
        OP_DSP_READ: begin
          // non-empty pop finishes on pop_commit
          if (in_item_i.port == PORT_MAILBOX && fifo_empty) begin
            irq_d = 1'b0;
          end
        end
        default: begin
          unique case (in_item_i.port)
            PORT_RAM_BANK: ram_bank_d = in_item_i.data_word[1:0];
            PORT_EXT_BANK: ext_bank_d = in_item_i.data_word;
            PORT_MAILBOX:  latch_d    = in_item_i.data_word;
            default:       ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      latch_q      <= '0;
      ready_flag_q <= 1'b1;
      ram_bank_q   <= '0;
      ext_bank_q   <= '0;
      irq_q        <= 1'b0;
    end else begin
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      latch_q      <= latch_d;
      ready_flag_q <= ready_flag_d;
      ram_bank_q   <= ram_bank_d;
      ext_bank_q   <= ext_bank_d;
      irq_q        <= irq_d;
    end
  end

  // command memory, registered read of the head slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= in_item_i.data_word;
    end
    head_q <= mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    dropped_q   <= dropped_d;
  end

  assign out_item_o.read_data   = read_data_q;
  assign out_item_o.irq_request = irq_q;
  assign out_item_o.ram_bank    = ram_bank_q;
  assign out_item_o.ext_bank    = ext_bank_q;
  assign out_item_o.dropped     = dropped_q;

endmodule

FILE: design/hcm_ctrl.sv
// ----------------------------------------------------------------------------
// hcm_ctrl
// Handshake controller: sequences execute, head fetch and result hold.
// ----------------------------------------------------------------------------
module hcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  hcm_pkg::dp_status_t status_i,
  output hcm_pkg::ctrl_cmd_t  ctrl_o
);
  import hcm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // a new transaction may enter in the cycle the held result is taken
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready_i);
  assign out_valid_o = (state_q == ST_RESP);
  assign accept      = in_valid_i && in_ready_o;

  assign ctrl_o.load_item  = accept;
  assign ctrl_o.pop_commit = (state_q == ST_FETCH);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.fetch_needed ? ST_FETCH : ST_RESP;
        end
      end
      ST_FETCH: state_d = ST_RESP;
      ST_RESP: begin
        if (accept) begin
          state_d = status_i.fetch_needed ? ST_FETCH : ST_RESP;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
